// ===== rtl/core/wicm_pkg.sv =====
package wicm_pkg;

	// Field widths of the request, result and config channels
	localparam int HEIGHT_W = 11;
	localparam int BEAUTY_W = 32;
	localparam int VAL_W    = 48;
	localparam int NUSED_W  = 11;

	// Default number of tree leaves
	localparam int MAX_POSITIONS_DEF = 1024;

	// Reset value of the n_used register
	localparam logic [NUSED_W-1:0] N_USED_RST = 11'd1024;

	// Sequence tag stored next to every tree node; a node whose tag differs
	// from the current one reads as zero
	localparam int EPOCH_W = 8;

endpackage

// ===== rtl/core/wicm_if.sv =====
interface wicm_req_if;
	logic                               valid;
	logic                               ready;
	logic [wicm_pkg::HEIGHT_W-1:0]      height;
	logic [wicm_pkg::BEAUTY_W-1:0]      beauty;
	logic                               new_sequence;

	modport source (output valid, height, beauty, new_sequence, input ready);
	modport sink   (input valid, height, beauty, new_sequence, output ready);
endinterface

interface wicm_res_if;
	logic                               valid;
	logic                               ready;
	logic [wicm_pkg::VAL_W-1:0]         chain_value;
	logic [wicm_pkg::VAL_W-1:0]         best_so_far;
	logic                               height_error;

	modport source (output valid, chain_value, best_so_far, height_error, input ready);
	modport sink   (input valid, chain_value, best_so_far, height_error, output ready);
endinterface

// ===== rtl/core/weighted_increasing_chain_max.sv =====
// Channel   Dir  Handshake          Payload
// req       in   req.valid/ready    height[10:0], beauty[31:0], new_sequence
// res       out  res.valid/ready    chain_value[47:0], best_so_far[47:0], height_error
// cfg       in   cfg_wr_en          cfg_wr_data[10:0] -> n_used
//
// One request at a time. A valid height takes a query walk (one tree level per
// cycle, both range ends read in parallel on the two RAM read ports, then a
// drain of the last read), an add step, an update walk (one sibling read and
// one parent write per level, then a drain of the last write), an output step
// and a return to idle; an invalid height skips the walks and the add step and
// goes straight to the output step. The RAM read latency sets the walk pace.
// After reset, and on every 2^EPOCH_W-th new_sequence, a clearing pass writes
// all 2*MAX_POSITIONS nodes, one per cycle, with req.ready low.
// A stalled result sits in the output register; the next request is still
// taken and its result waits in the final state until the register frees up.
module weighted_increasing_chain_max #(
	parameter int MAX_POSITIONS = wicm_pkg::MAX_POSITIONS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_wr_en,
	input  logic [wicm_pkg::NUSED_W-1:0]      cfg_wr_data,
	wicm_req_if.sink                          req,
	wicm_res_if.source                        res
);

	localparam int DEPTH = 2 * MAX_POSITIONS;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;
	localparam int VW    = wicm_pkg::VAL_W;
	localparam int EW    = wicm_pkg::EPOCH_W;
	localparam int MW    = VW + EW;
	localparam int BW    = wicm_pkg::BEAUTY_W;

	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [31:0]   MAX_POS32 = 32'(MAX_POSITIONS);

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_QUERY  = 6'b000100,
		ST_ADD    = 6'b001000,
		ST_UPDATE = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	// control state
	state_t                 state_q;
	logic [wicm_pkg::NUSED_W-1:0] n_used_q;
	logic [EW-1:0]          epoch_q;
	logic [VW-1:0]          best_q;
	logic [AW-1:0]          clr_cnt_q;
	logic                   boot_q;
	logic                   ok_q;
	logic                   pend_s1;
	logic                   upv_s1;
	logic                   out_valid_q;

	// payload
	logic [BW-1:0]          beauty_q;
	logic [AW-1:0]          leaf_q;
	logic [CW-1:0]          lo_q;
	logic [CW-1:0]          hi_q;
	logic [VW-1:0]          res_q;
	logic                   fa_s1;
	logic                   fb_s1;
	logic [AW-1:0]          i_q;
	logic [AW-1:0]          par_s1;
	logic [VW-1:0]          cur_q;
	logic [VW-1:0]          chain_q;
	logic [VW-1:0]          out_chain_q;
	logic [VW-1:0]          out_best_q;
	logic                   out_err_q;

	// RAM ports
	logic                   mem_we;
	logic [AW-1:0]          mem_waddr;
	logic [MW-1:0]          mem_wdata;
	logic [AW-1:0]          mem_raddr_a;
	logic [AW-1:0]          mem_raddr_b;
	logic [MW-1:0]          mem_rdata_a;
	logic [MW-1:0]          mem_rdata_b;

	logic                   acc;
	logic                   h_ok;
	logic                   epoch_full;
	logic                   q_issue;
	logic                   u_issue;
	logic [CW-1:0]          hi_m1;
	logic [VW-1:0]          rd_a_val;
	logic [VW-1:0]          rd_b_val;
	logic [VW-1:0]          q_max1;
	logic [VW-1:0]          q_max2;
	logic [VW:0]            sum;
	logic [VW-1:0]          chain_d;
	logic [VW-1:0]          upd_v;
	logic                   out_load;

	wicm_ram #(
		.WIDTH (MW),
		.DEPTH (DEPTH)
	) u_tree (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.rdata_a (mem_rdata_a),
		.raddr_b (mem_raddr_b),
		.rdata_b (mem_rdata_b)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign acc       = req.valid && req.ready;

	// Valid range is 1..min(n_used, MAX_POSITIONS)
	assign h_ok = (req.height != '0) && (req.height <= n_used_q) &&
		(32'(req.height) <= MAX_POS32);

	assign epoch_full = (epoch_q == {EW{1'b1}});

	// Query walk: keep going while the half-open range [lo, hi) is not empty
	assign q_issue = (lo_q < hi_q);
	assign hi_m1   = hi_q - CW'(1);
	// Update walk: climb until the root has been written
	assign u_issue = (i_q > AW'(1));

	// Drop nodes stamped by an older sequence: they read as zero
	assign rd_a_val = (mem_rdata_a[MW-1 -: EW] == epoch_q) ? mem_rdata_a[VW-1:0] : '0;
	assign rd_b_val = (mem_rdata_b[MW-1 -: EW] == epoch_q) ? mem_rdata_b[VW-1:0] : '0;

	// Fold the returned range ends into the running maximum
	assign q_max1 = (fa_s1 && (rd_a_val > res_q)) ? rd_a_val : res_q;
	assign q_max2 = (fb_s1 && (rd_b_val > q_max1)) ? rd_b_val : q_max1;

	// Saturate the new chain value at 2^48-1
	assign sum     = {1'b0, res_q} + (VW + 1)'(beauty_q);
	assign chain_d = sum[VW] ? {VW{1'b1}} : sum[VW-1:0];

	// Parent = max(node on the path, its sibling)
	assign upd_v = (rd_a_val > cur_q) ? rd_a_val : cur_q;

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || res.ready);

	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = clr_cnt_q;
		mem_wdata   = '0;
		mem_raddr_a = lo_q[AW-1:0];
		mem_raddr_b = hi_m1[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_ADD: begin
				// write the leaf now; the walk starts from its value
				mem_we    = 1'b1;
				mem_waddr = leaf_q;
				mem_wdata = {epoch_q, chain_d};
			end
			ST_UPDATE: begin
				mem_raddr_a = i_q ^ AW'(1);
				if (upv_s1) begin
					mem_we    = 1'b1;
					mem_waddr = par_s1;
					mem_wdata = {epoch_q, upd_v};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			n_used_q    <= wicm_pkg::N_USED_RST;
			epoch_q     <= '0;
			best_q      <= '0;
			clr_cnt_q   <= '0;
			boot_q      <= 1'b1;
			ok_q        <= 1'b0;
			pend_s1     <= 1'b0;
			upv_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				n_used_q <= cfg_wr_data;
			end

			pend_s1 <= (state_q == ST_QUERY) && q_issue;
			upv_s1  <= (state_q == ST_UPDATE) && u_issue;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_cnt_q <= clr_cnt_q + AW'(1);
					if (clr_cnt_q == LAST_ADDR) begin
						boot_q <= 1'b0;
						if (boot_q) begin
							state_q <= ST_IDLE;
						end else if (ok_q) begin
							state_q <= ST_QUERY;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_IDLE: begin
					if (acc) begin
						ok_q <= h_ok;
						if (req.new_sequence) begin
							best_q <= '0;
						end
						if (req.new_sequence && epoch_full) begin
							// tags are used up: wipe the tree and restart them
							epoch_q   <= '0;
							clr_cnt_q <= '0;
							state_q   <= ST_CLEAR;
						end else begin
							if (req.new_sequence) begin
								epoch_q <= epoch_q + EW'(1);
							end
							state_q <= h_ok ? ST_QUERY : ST_DONE;
						end
					end
				end
				ST_QUERY: begin
					if (!q_issue && !pend_s1) begin
						state_q <= ST_ADD;
					end
				end
				ST_ADD: begin
					if (chain_d > best_q) begin
						best_q <= chain_d;
					end
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (!u_issue && !upv_s1) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			beauty_q <= req.beauty;
			leaf_q   <= AW'(MAX_POSITIONS) + AW'(req.height) - AW'(1);
			lo_q     <= CW'(MAX_POSITIONS);
			hi_q     <= CW'(MAX_POSITIONS) + CW'(req.height);
			res_q    <= '0;
			chain_q  <= '0;
		end

		if (state_q == ST_QUERY) begin
			fa_s1 <= q_issue && lo_q[0];
			fb_s1 <= q_issue && hi_q[0];
			if (q_issue) begin
				// advance both range ends one level up
				lo_q <= (lo_q + CW'(lo_q[0])) >> 1;
				hi_q <= hi_q >> 1;
			end
			if (pend_s1) begin
				res_q <= q_max2;
			end
		end

		if (state_q == ST_ADD) begin
			chain_q <= chain_d;
			cur_q   <= chain_d;
			i_q     <= leaf_q;
		end

		if (state_q == ST_UPDATE) begin
			if (u_issue) begin
				i_q    <= i_q >> 1;
				par_s1 <= i_q >> 1;
			end
			if (upv_s1) begin
				cur_q <= upd_v;
			end
		end

		if (out_load) begin
			out_chain_q <= chain_q;
			out_best_q  <= best_q;
			out_err_q   <= !ok_q;
		end
	end

	assign res.valid        = out_valid_q;
	assign res.chain_value  = out_chain_q;
	assign res.best_so_far  = out_best_q;
	assign res.height_error = out_err_q;

	// An error result carries a zero chain value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.height_error |-> res.chain_value == '0)
		else $error("height error result with nonzero chain value");

	// The running best never falls below the chain value it is reported with
	a_best_ge: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.best_so_far >= res.chain_value)
		else $error("best_so_far below chain_value");

	// A new sequence always moves to a fresh tag
	a_epoch: assert property (@(posedge clk) disable iff (!arst_n)
		acc && req.new_sequence |=> epoch_q != $past(epoch_q))
		else $error("new sequence kept the old tag");

	// The update walk never writes node zero
	a_no_node0: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE) && mem_we |-> mem_waddr != '0)
		else $error("tree update wrote node zero");

endmodule

// ===== rtl/core/wicm_ram.sv =====
module wicm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule
